>>> sv/bevacc_pkg.sv
// Shared constants, types and arithmetic helpers of the bilinear event vote accumulator.
// Used by bilinear_event_vote_accumulator and its port checker; depends on nothing.
package bevacc_pkg;

    // Map geometry and number formats.
    localparam int MAP_WIDTH       = 1024;
    localparam int MAP_HEIGHT      = 512;
    localparam int COORD_FRAC_BITS = 8;
    localparam int ACC_WIDTH       = 32;

    localparam int MAP_CELLS = MAP_WIDTH * MAP_HEIGHT;
    localparam int ADDR_W    = $clog2(MAP_CELLS);

    // Port field widths.
    localparam int KIND_W     = 2;
    localparam int PX_W       = 18;
    localparam int PY_W       = 17;
    localparam int TIME_W     = 32;
    localparam int SUM_W      = 32;
    localparam int COMB_W     = 33;
    localparam int MW_W       = 11;
    localparam int MH_W       = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Bound compares run at this width; it holds every coordinate and map size in range.
    localparam int CMP_W = 16;

    // Bilinear weight arithmetic: fractions, products and the 16 fraction bit result.
    localparam int ONE_W   = COORD_FRAC_BITS + 1;
    localparam int PROD_W  = 2 * ONE_W;
    localparam int WGT_W   = 17;
    localparam int PF      = 2 * COORD_FRAC_BITS;
    localparam int SH_L    = (PF <= 16) ? (16 - PF) : 0;
    localparam int SH_R    = (PF > 16) ? (PF - 16) : 0;
    localparam int RND_SH  = (SH_R > 0) ? (SH_R - 1) : 0;
    localparam int T_W     = PROD_W + 17;

    localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_VOTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_TIME = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC,
        ST_VOTE,
        ST_READ_DATA,
        ST_FINISH
    } state_t;

    // One result beat.
    typedef struct packed {
        logic              vote_accepted;
        logic              went_to_old;
        logic [SUM_W-1:0]  old_sum;
        logic [SUM_W-1:0]  new_sum;
        logic [COMB_W-1:0] combined_sum;
        logic              saturated;
    } result_t;

    // Product of two fraction weights, brought to 16 fraction bits.
    function automatic logic [WGT_W-1:0] bilinear_weight(
        input logic [ONE_W-1:0] a,
        input logic [ONE_W-1:0] b
    );
        logic [PROD_W-1:0] p;
        logic [T_W-1:0]    t;
        p = PROD_W'(a) * PROD_W'(b);
        t = ((T_W'(p) + (T_W'(SH_R > 0) << RND_SH)) >> SH_R) << SH_L;
        return t[WGT_W-1:0];
    endfunction

endpackage

>>> sv/bevacc_ram.sv
// Generic memory with one write port and one registered read port.
// Stand-alone; instanced for each accumulator map.
module bevacc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/bilinear_event_vote_accumulator.sv
// Top level of the bilinear event vote accumulator: sequencer, shared weight and add unit.
// Depends on bevacc_pkg and two bevacc_ram instances for the old and new maps.
//
// The block takes one item at a time. An item passes EXEC, then VOTE for a vote or
// READ_DATA for a pixel read, then FINISH, which hands its result to the output register;
// the next item is taken after that. When the point fails the bounds check, or the kind is
// unused, the item goes from EXEC straight to FINISH. For an accepted vote the four
// neighbouring pixels are read, given their bilinear weight by one shared multiplier and
// written back by one shared saturating adder, one pixel a cycle through the map memory's
// read and write ports. After reset, and for every clear item, the block sweeps both maps
// to zero, one address a cycle. No item is accepted during the sweep, but configuration
// writes are. A finished result waits in the output register while the next item is
// accepted. When that register is still full, the block holds in FINISH until the
// receiver takes the waiting beat.
module bilinear_event_vote_accumulator (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bevacc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bevacc_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input item channel.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bevacc_pkg::KIND_W-1:0]     kind,
    input  logic [bevacc_pkg::PX_W-1:0]       point_x,
    input  logic [bevacc_pkg::PY_W-1:0]       point_y,
    input  logic [bevacc_pkg::TIME_W-1:0]     event_time,
    // Result channel.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              vote_accepted,
    output logic                              went_to_old,
    output logic [bevacc_pkg::SUM_W-1:0]      old_sum,
    output logic [bevacc_pkg::SUM_W-1:0]      new_sum,
    output logic [bevacc_pkg::COMB_W-1:0]     combined_sum,
    output logic                              saturated
);

    import bevacc_pkg::*;

    localparam logic [ONE_W-1:0]  ONE      = ONE_W'(1) << COORD_FRAC_BITS;
    localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(MAP_CELLS - 1);
    localparam logic [2:0]        LAST_STEP = 3'd4;

    state_t state_reg, state_next;

    logic [MW_W-1:0]     map_width_reg,  map_width_next;
    logic [MH_W-1:0]     map_height_reg, map_height_next;
    logic [TIME_W-1:0]   split_reg,      split_next;

    logic [KIND_W-1:0]   kind_reg,  kind_next;
    logic [PX_W-1:0]     px_reg,    px_next;
    logic [PY_W-1:0]     py_reg,    py_next;
    logic [TIME_W-1:0]   time_reg,  time_next;

    logic [ADDR_W-1:0]   base_reg,    base_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [2:0]          step_reg,    step_next;
    logic [WGT_W-1:0]    wgt_reg,     wgt_next;
    logic                old_sel_reg, old_sel_next;
    logic                sat_reg,     sat_next;
    logic                res_pend_reg, res_pend_next;
    result_t             res_reg,     res_next;
    result_t             out_reg,     out_next;
    logic                out_valid_reg, out_valid_next;

    // Memory port signals.
    logic                ram_rd_addr_sel;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [ACC_WIDTH-1:0] ram_wr_data;
    logic                old_wr_en, new_wr_en;
    logic [ACC_WIDTH-1:0] old_rd_data, new_rd_data, map_rd_data;

    // Decoded item.
    logic [CMP_W-1:0]    xi, yi, act_w, act_h;
    logic [COORD_FRAC_BITS-1:0] fx, fy;
    logic                vote_ok, read_ok;
    logic [ADDR_W-1:0]   base_addr, pix_addr;
    logic [ONE_W-1:0]    wx, wy;

    // Shared saturating adder and read evaluation.
    logic [ACC_WIDTH:0]  acc_sum;
    logic                acc_clip;
    logic [ACC_WIDTH-1:0] acc_val;
    logic [63:0]         rd_old64, rd_new64, rd_comb64;
    result_t             read_res;

    logic                sweep_last;
    logic                out_free;

    // Integer and fraction parts of the latched point, and the active map size.
    always_comb
    begin
        xi    = CMP_W'(px_reg[PX_W-1:COORD_FRAC_BITS]);
        yi    = CMP_W'(py_reg[PY_W-1:COORD_FRAC_BITS]);
        fx    = px_reg[COORD_FRAC_BITS-1:0];
        fy    = py_reg[COORD_FRAC_BITS-1:0];
        act_w = (CMP_W'(map_width_reg) > CMP_W'(MAP_WIDTH)) ?
                CMP_W'(MAP_WIDTH) : CMP_W'(map_width_reg);
        act_h = (CMP_W'(map_height_reg) > CMP_W'(MAP_HEIGHT)) ?
                CMP_W'(MAP_HEIGHT) : CMP_W'(map_height_reg);
        vote_ok = (xi >= CMP_W'(1)) && ((xi + CMP_W'(2)) < act_w) &&
                  (yi >= CMP_W'(1)) && ((yi + CMP_W'(2)) < act_h);
        read_ok = (xi < act_w) && (yi < act_h);
    end

    // Row-major pixel address; the step picks one of the four neighbours.
    always_comb
    begin
        base_addr = ADDR_W'(py_reg[PY_W-1:COORD_FRAC_BITS]) * ADDR_W'(MAP_WIDTH) +
                    ADDR_W'(px_reg[PX_W-1:COORD_FRAC_BITS]);
        pix_addr  = base_reg + ADDR_W'(step_reg[0]) +
                    (step_reg[1] ? ADDR_W'(MAP_WIDTH) : ADDR_W'(0));
        wx = step_reg[0] ? ONE_W'(fx) : (ONE - ONE_W'(fx));
        wy = step_reg[1] ? ONE_W'(fy) : (ONE - ONE_W'(fy));
    end

    // Saturating add of the stored weight to the pixel that has just been read.
    always_comb
    begin
        map_rd_data = old_sel_reg ? old_rd_data : new_rd_data;
        acc_sum     = (ACC_WIDTH + 1)'(map_rd_data) + (ACC_WIDTH + 1)'(wgt_reg);
        acc_clip    = acc_sum[ACC_WIDTH];
        acc_val     = acc_clip ? ACC_MAX : acc_sum[ACC_WIDTH-1:0];
    end

    // Pixel read: both maps, their sum and the clipping to the output fields.
    always_comb
    begin
        rd_old64  = 64'(old_rd_data);
        rd_new64  = 64'(new_rd_data);
        rd_comb64 = rd_old64 + rd_new64;
        read_res  = '0;
        read_res.saturated = (old_rd_data == ACC_MAX) || (new_rd_data == ACC_MAX);
        if (rd_comb64 > 64'h1_FFFF_FFFF)
        begin
            read_res.combined_sum = '1;
            read_res.saturated    = 1'b1;
        end
        else
        begin
            read_res.combined_sum = rd_comb64[COMB_W-1:0];
        end
        if (rd_old64 > 64'hFFFF_FFFF)
        begin
            read_res.old_sum   = '1;
            read_res.saturated = 1'b1;
        end
        else
        begin
            read_res.old_sum = rd_old64[SUM_W-1:0];
        end
        if (rd_new64 > 64'hFFFF_FFFF)
        begin
            read_res.new_sum   = '1;
            read_res.saturated = 1'b1;
        end
        else
        begin
            read_res.new_sum = rd_new64[SUM_W-1:0];
        end
    end

    assign sweep_last = (clr_cnt_reg == LAST_ADR);
    assign out_free   = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = res_pend_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (kind_reg)
                    KIND_VOTE:  state_next = vote_ok ? ST_VOTE : ST_FINISH;
                    KIND_READ:  state_next = read_ok ? ST_READ_DATA : ST_FINISH;
                    KIND_CLEAR: state_next = ST_SWEEP;
                    default:    state_next = ST_FINISH;
                endcase
            end
            ST_VOTE:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ_DATA:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and memory port controls.
    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        cfg_ready       = 1'b1;
        ram_rd_addr_sel = (state_reg == ST_EXEC);
        ram_rd_addr     = ram_rd_addr_sel ? base_addr : pix_addr;
        old_wr_en       = 1'b0;
        new_wr_en       = 1'b0;
        ram_wr_addr     = wr_addr_reg;
        ram_wr_data     = acc_val;
        if (state_reg == ST_SWEEP)
        begin
            old_wr_en   = 1'b1;
            new_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_reg;
            ram_wr_data = '0;
        end
        else if ((state_reg == ST_VOTE) && (step_reg != 3'd0))
        begin
            old_wr_en = old_sel_reg;
            new_wr_en = !old_sel_reg;
        end
    end

    // Datapath and register next values.
    always_comb
    begin
        map_width_next  = map_width_reg;
        map_height_next = map_height_reg;
        split_next      = split_reg;
        kind_next       = kind_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        time_next       = time_reg;
        base_next       = base_reg;
        wr_addr_next    = wr_addr_reg;
        clr_cnt_next    = clr_cnt_reg;
        step_next       = step_reg;
        wgt_next        = wgt_reg;
        old_sel_next    = old_sel_reg;
        sat_next        = sat_reg;
        res_pend_next   = res_pend_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        // Configuration writes; indexes past the list are ignored.
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAP_WIDTH:  map_width_next  = cfg_data[MW_W-1:0];
                CFG_MAP_HEIGHT: map_height_next = cfg_data[MH_W-1:0];
                CFG_SPLIT_TIME: split_next      = cfg_data[TIME_W-1:0];
                default:        ;
            endcase
        end

        // The result register empties when its beat is taken.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SWEEP:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (sweep_last)
                begin
                    res_pend_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind;
                    px_next   = point_x;
                    py_next   = point_y;
                    time_next = event_time;
                end
            end
            ST_EXEC:
            begin
                base_next    = base_addr;
                step_next    = 3'd0;
                sat_next     = 1'b0;
                old_sel_next = (time_reg < split_reg);
                res_next     = '0;
                if (kind_reg == KIND_CLEAR)
                begin
                    clr_cnt_next  = '0;
                    res_pend_next = 1'b1;
                end
            end
            ST_VOTE:
            begin
                // Read pixel k and weigh it; write back pixel k-1.
                wgt_next     = bilinear_weight(wx, wy);
                wr_addr_next = pix_addr;
                step_next    = step_reg + 3'd1;
                if (step_reg != 3'd0)
                begin
                    sat_next = sat_reg | acc_clip;
                end
                if (step_reg == LAST_STEP)
                begin
                    res_next.vote_accepted = 1'b1;
                    res_next.went_to_old   = old_sel_reg;
                    res_next.saturated     = sat_reg | acc_clip;
                end
            end
            ST_READ_DATA:
            begin
                res_next = read_res;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            clr_cnt_reg    <= '0;
            res_pend_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            step_reg       <= '0;
            map_width_reg  <= MW_W'(1024);
            map_height_reg <= MH_W'(512);
            split_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            res_pend_reg   <= res_pend_next;
            out_valid_reg  <= out_valid_next;
            step_reg       <= step_next;
            map_width_reg  <= map_width_next;
            map_height_reg <= map_height_next;
            split_reg      <= split_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        time_reg    <= time_next;
        base_reg    <= base_next;
        wr_addr_reg <= wr_addr_next;
        wgt_reg     <= wgt_next;
        old_sel_reg <= old_sel_next;
        sat_reg     <= sat_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    // Old and new window maps.
    bevacc_ram #(
        .WIDTH (ACC_WIDTH),
        .DEPTH (MAP_CELLS)
    ) u_old_map (
        .clk     (clk),
        .wr_en   (old_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (old_rd_data)
    );

    bevacc_ram #(
        .WIDTH (ACC_WIDTH),
        .DEPTH (MAP_CELLS)
    ) u_new_map (
        .clk     (clk),
        .wr_en   (new_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (new_rd_data)
    );

    // Result ports.
    assign out_valid     = out_valid_reg;
    assign vote_accepted = out_reg.vote_accepted;
    assign went_to_old   = out_reg.went_to_old;
    assign old_sum       = out_reg.old_sum;
    assign new_sum       = out_reg.new_sum;
    assign combined_sum  = out_reg.combined_sum;
    assign saturated     = out_reg.saturated;

endmodule

>>> sv/bevacc_checker.sv
// Port-level checker for bilinear_event_vote_accumulator, attached by the bind below.
// Depends on bevacc_pkg for the port widths.
module bevacc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [bevacc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [bevacc_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic [bevacc_pkg::KIND_W-1:0]     kind,
    input logic [bevacc_pkg::PX_W-1:0]       point_x,
    input logic [bevacc_pkg::PY_W-1:0]       point_y,
    input logic [bevacc_pkg::TIME_W-1:0]     event_time,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              vote_accepted,
    input logic                              went_to_old,
    input logic [bevacc_pkg::SUM_W-1:0]      old_sum,
    input logic [bevacc_pkg::SUM_W-1:0]      new_sum,
    input logic [bevacc_pkg::COMB_W-1:0]     combined_sum,
    input logic                              saturated
);

    import bevacc_pkg::*;

    // A result beat that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before it was taken");

    // One item at a time: the input side closes right after a beat is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is still in work");

    // A vote result carries no pixel sums.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && vote_accepted |->
            (old_sum == '0) && (new_sum == '0) && (combined_sum == '0))
        else $error("vote result carries pixel sums");

    // The map choice is only reported for an accepted vote.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !vote_accepted |-> !went_to_old)
        else $error("map choice reported without an accepted vote");

    // Without clipping the combined sum is the exact sum of both maps.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !saturated |->
            (combined_sum == (COMB_W'(old_sum) + COMB_W'(new_sum))))
        else $error("combined sum differs from old plus new");

endmodule

bind bilinear_event_vote_accumulator bevacc_checker u_bevacc_checker (.*);

>>> tb/tb_bilinear_event_vote_accumulator.sv
`timescale 1ns / 1ps
// Self-checking testbench for bilinear_event_vote_accumulator: directed and random votes,
// pixel reads and a map clear, with every result beat compared against an in-bench map model.
// Depends on bevacc_pkg and the accumulator RTL; reads no files.
module tb_bilinear_event_vote_accumulator;
    import bevacc_pkg::*;

    localparam int     CLK_PERIOD   = 8;
    localparam int     RESET_CYCLES = 10;
    localparam longint CYCLE_LIMIT  = 6_000_000;
    localparam int     LONG_HOLD    = 300;
    localparam int     DRAIN_CYCLES = 32;
    localparam int     FRAC_MAX     = (1 << COORD_FRAC_BITS) - 1;

    // Kind code that the block must ignore.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam logic [63:0] ACC_CEILING  = (64'd1 << ACC_WIDTH) - 64'd1;
    localparam logic [63:0] SUM_CEILING  = (64'd1 << SUM_W) - 64'd1;
    localparam logic [63:0] COMB_CEILING = (64'd1 << COMB_W) - 64'd1;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [KIND_W-1:0]     kind;
    logic [PX_W-1:0]       point_x;
    logic [PY_W-1:0]       point_y;
    logic [TIME_W-1:0]     event_time;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  vote_accepted;
    logic                  went_to_old;
    logic [SUM_W-1:0]      old_sum;
    logic [SUM_W-1:0]      new_sum;
    logic [COMB_W-1:0]     combined_sum;
    logic                  saturated;

    // Map model, register copies and the queue of result beats still owed by the block.
    logic [63:0]       old_cells [int];
    logic [63:0]       new_cells [int];
    logic [MW_W-1:0]   width_setting  = 11'd1024;
    logic [MH_W-1:0]   height_setting = 10'd512;
    logic [TIME_W-1:0] split_setting  = '0;
    result_t           owed_results [$];

    int     fail_count   = 0;
    bit     idle_on      = 1'b0;
    bit     hold_request = 1'b0;
    int     ready_hold   = 0;
    longint cycle_count  = 0;

    bilinear_event_vote_accumulator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .point_x      (point_x),
        .point_y      (point_y),
        .event_time   (event_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vote_accepted(vote_accepted),
        .went_to_old  (went_to_old),
        .old_sum      (old_sum),
        .new_sum      (new_sum),
        .combined_sum (combined_sum),
        .saturated    (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Idle length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Fixed-point coordinate from a whole pixel index and a fraction.
    function automatic logic [31:0] to_fixed(int whole, int frac);
        return (32'(whole) << COORD_FRAC_BITS) | 32'(frac);
    endfunction

    // Pixel index on or next to the border of the guarded interior.
    function automatic int edge_index(int size, int top);
        int v;
        case ($urandom_range(0, 4))
            0: v = 0;
            1: v = 1;
            2: v = size - 3;
            3: v = size - 2;
            default: v = size - 1;
        endcase
        if (v < 0)
        begin
            v = 0;
        end
        if (v > top)
        begin
            v = top;
        end
        return v;
    endfunction

    // Timestamp that often sits right at the window split.
    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0: return split_setting;
            1: return split_setting - 1'b1;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Bilinear weight product scaled to 16 fraction bits.
    function automatic logic [63:0] frac_product_q16(logic [63:0] a, logic [63:0] b);
        logic [63:0] prod;
        int          prod_frac;
        prod      = a * b;
        prod_frac = 2 * COORD_FRAC_BITS;
        if (prod_frac <= 16)
        begin
            return prod << (16 - prod_frac);
        end
        return (prod + (64'd1 << (prod_frac - 17))) >> (prod_frac - 16);
    endfunction

    function automatic logic [63:0] cell_value(bit from_old, int addr);
        if (from_old)
        begin
            return old_cells.exists(addr) ? old_cells[addr] : 64'd0;
        end
        return new_cells.exists(addr) ? new_cells[addr] : 64'd0;
    endfunction

    // Saturating accumulate into one model cell; returns 1 when the cell clipped.
    function automatic bit add_to_cell(bit to_old, int addr, logic [63:0] weight);
        logic [63:0] v;
        bit          clipped;
        v       = cell_value(to_old, addr) & ACC_CEILING;
        clipped = weight > ACC_CEILING - v;
        v       = clipped ? ACC_CEILING : v + weight;
        if (to_old)
        begin
            old_cells[addr] = v;
        end
        else
        begin
            new_cells[addr] = v;
        end
        return clipped;
    endfunction

    // Applies one item to the map model and returns the beat the block must produce.
    function automatic result_t accumulate_item(logic [KIND_W-1:0] k, logic [PX_W-1:0] px,
                                                logic [PY_W-1:0] py, logic [TIME_W-1:0] t);
        result_t     r;
        logic [63:0] one, fx, fy, o, n, c;
        int          xi, yi, w, h, addr;
        bit          to_old, clipped;
        r   = '0;
        one = 64'd1 << COORD_FRAC_BITS;
        fx  = 64'(px) & (one - 1);
        fy  = 64'(py) & (one - 1);
        xi  = int'(px >> COORD_FRAC_BITS);
        yi  = int'(py >> COORD_FRAC_BITS);
        w   = (int'(width_setting) > MAP_WIDTH) ? MAP_WIDTH : int'(width_setting);
        h   = (int'(height_setting) > MAP_HEIGHT) ? MAP_HEIGHT : int'(height_setting);
        case (k)
            KIND_VOTE:
            begin
                if (xi >= 1 && xi + 2 < w && yi >= 1 && yi + 2 < h)
                begin
                    to_old  = t < split_setting;
                    addr    = yi * MAP_WIDTH + xi;
                    clipped = add_to_cell(to_old, addr, frac_product_q16(one - fx, one - fy));
                    clipped |= add_to_cell(to_old, addr + 1, frac_product_q16(fx, one - fy));
                    clipped |= add_to_cell(to_old, addr + MAP_WIDTH,
                                           frac_product_q16(one - fx, fy));
                    clipped |= add_to_cell(to_old, addr + MAP_WIDTH + 1, frac_product_q16(fx, fy));
                    r.vote_accepted = 1'b1;
                    r.went_to_old   = to_old;
                    r.saturated     = clipped;
                end
            end
            KIND_READ:
            begin
                if (xi < w && yi < h)
                begin
                    addr    = yi * MAP_WIDTH + xi;
                    o       = cell_value(1'b1, addr) & ACC_CEILING;
                    n       = cell_value(1'b0, addr) & ACC_CEILING;
                    clipped = (o == ACC_CEILING) || (n == ACC_CEILING);
                    c       = o + n;
                    if (c > COMB_CEILING)
                    begin
                        c       = COMB_CEILING;
                        clipped = 1'b1;
                    end
                    if (o > SUM_CEILING)
                    begin
                        o       = SUM_CEILING;
                        clipped = 1'b1;
                    end
                    if (n > SUM_CEILING)
                    begin
                        n       = SUM_CEILING;
                        clipped = 1'b1;
                    end
                    r.old_sum      = o[SUM_W-1:0];
                    r.new_sum      = n[SUM_W-1:0];
                    r.combined_sum = c[COMB_W-1:0];
                    r.saturated    = clipped;
                end
            end
            KIND_CLEAR:
            begin
                old_cells.delete();
                new_cells.delete();
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string field, logic [63:0] want_v, logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want_v, got_v);
            fail_count++;
        end
    endfunction

    // Offers one input beat after a random idle stretch and records its expected result.
    // Coordinates come in 32 bits wide and are cut to the port widths here.
    task automatic send_item(input logic [KIND_W-1:0] k, input logic [31:0] px,
                             input logic [31:0] py, input logic [TIME_W-1:0] t);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        kind       <= k;
        point_x    <= px[PX_W-1:0];
        point_y    <= py[PY_W-1:0];
        event_time <= t;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        owed_results.insert(owed_results.size(),
                            accumulate_item(k, px[PX_W-1:0], py[PY_W-1:0], t));
    endtask

    // Stops offering items and waits until every owed result beat has been taken.
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            CFG_MAP_WIDTH:  width_setting  = value[MW_W-1:0];
            CFG_MAP_HEIGHT: height_setting = value[MH_W-1:0];
            CFG_SPLIT_TIME: split_setting  = value[TIME_W-1:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input int w_set, input int h_set, input logic [31:0] split);
        wait_results_drained();
        write_register(CFG_MAP_WIDTH, 32'(w_set));
        write_register(CFG_MAP_HEIGHT, 32'(h_set));
        write_register(CFG_SPLIT_TIME, split);
    endtask

    // Border pixels, whole and split weights, out-of-range reads and the ignored kind.
    task automatic test_extreme_points();
        set_geometry(1024, 512, '0);
        idle_on = 1'b0;
        send_item(KIND_VOTE, to_fixed(1, 0), to_fixed(1, 0), '0);
        send_item(KIND_VOTE, to_fixed(1021, FRAC_MAX), to_fixed(509, FRAC_MAX), '1);
        send_item(KIND_VOTE, to_fixed(0, 128), to_fixed(5, 0), 32'd77);
        send_item(KIND_VOTE, to_fixed(1022, 0), to_fixed(5, 0), 32'd78);
        send_item(KIND_VOTE, to_fixed(5, 0), to_fixed(0, FRAC_MAX), 32'd79);
        send_item(KIND_VOTE, to_fixed(5, 0), to_fixed(510, 0), 32'd80);
        send_item(KIND_VOTE, '1, '1, 32'h8000_0000);
        send_item(KIND_VOTE, to_fixed(5, 128), to_fixed(7, 64), 32'h5555_5555);
        send_item(KIND_READ, to_fixed(1, 0), to_fixed(1, 0), '0);
        send_item(KIND_READ, to_fixed(1022, FRAC_MAX), to_fixed(510, FRAC_MAX), '0);
        send_item(KIND_READ, to_fixed(6, 0), to_fixed(8, 0), '0);
        send_item(KIND_READ, '1, '1, '1);
        send_item(KIND_SPARE, '1, '1, '1);
    endtask

    // Votes on both sides of the window split, including the split value itself.
    task automatic test_split_boundary();
        set_geometry(1024, 512, '1);
        send_item(KIND_VOTE, to_fixed(5, 0), to_fixed(7, 0), 32'hFFFF_FFFE);
        send_item(KIND_VOTE, to_fixed(5, 0), to_fixed(7, 0), 32'hFFFF_FFFF);
        wait_results_drained();
        write_register(CFG_SPLIT_TIME, 32'd1000);
        send_item(KIND_VOTE, to_fixed(5, 0), to_fixed(7, 0), 32'd999);
        send_item(KIND_VOTE, to_fixed(5, 0), to_fixed(7, 0), 32'd1000);
        send_item(KIND_READ, to_fixed(5, 0), to_fixed(7, 0), '0);
    endtask

    // A clear wipes both maps; reads of formerly voted pixels come back zero.
    task automatic test_clear_maps();
        send_item(KIND_CLEAR, $urandom, $urandom, $urandom);
        send_item(KIND_READ, to_fixed(5, 0), to_fixed(7, 0), '0);
        send_item(KIND_READ, to_fixed(1, 0), to_fixed(1, 0), '0);
    endtask

    // Smallest interior, and a size too small to hold any interior at all.
    task automatic test_tiny_sizes();
        set_geometry(4, 4, 32'h1000);
        send_item(KIND_VOTE, to_fixed(1, 200), to_fixed(1, 30), 32'h0FFF);
        send_item(KIND_VOTE, to_fixed(2, 0), to_fixed(1, 0), 32'h1000);
        send_item(KIND_VOTE, to_fixed(1, 0), to_fixed(2, 0), 32'h1000);
        send_item(KIND_READ, to_fixed(2, 0), to_fixed(2, 0), '0);
        send_item(KIND_READ, to_fixed(4, 0), to_fixed(0, 0), '0);
        set_geometry(3, 3, 32'h1000);
        send_item(KIND_VOTE, to_fixed(1, 0), to_fixed(1, 0), '0);
        send_item(KIND_READ, to_fixed(2, 0), to_fixed(1, 0), '0);
        send_item(KIND_READ, to_fixed(1, 0), to_fixed(3, 0), '0);
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the block backs up.
    task automatic test_output_backpressure();
        wait_results_drained();
        idle_on      = 1'b0;
        hold_request = 1'b1;
        repeat (16)
        begin
            if ($urandom_range(0, 1))
            begin
                send_item(KIND_VOTE, to_fixed($urandom_range(3, 8), $urandom_range(0, FRAC_MAX)),
                          to_fixed($urandom_range(3, 8), $urandom_range(0, FRAC_MAX)), pick_time());
            end
            else
            begin
                send_item(KIND_READ, to_fixed($urandom_range(3, 9), 0),
                          to_fixed($urandom_range(3, 9), 0), '0);
            end
        end
    endtask

    // Random items around a small hotspot so reads see accumulated votes, plus border and noise.
    task automatic run_random_phase(input int item_count, input int w_set, input int h_set,
                                    input logic [31:0] split, input bit with_idle);
        int w, h, base_x, base_y, roll;
        set_geometry(w_set, h_set, split);
        idle_on = with_idle;
        w       = (w_set > MAP_WIDTH) ? MAP_WIDTH : w_set;
        h       = (h_set > MAP_HEIGHT) ? MAP_HEIGHT : h_set;
        base_x  = (w > 6) ? $urandom_range(1, w - 6) : 1;
        base_y  = (h > 6) ? $urandom_range(1, h - 6) : 1;
        repeat (item_count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                send_item(KIND_VOTE,
                          to_fixed($urandom_range(base_x, base_x + 3), $urandom_range(0, FRAC_MAX)),
                          to_fixed($urandom_range(base_y, base_y + 3), $urandom_range(0, FRAC_MAX)),
                          pick_time());
            end
            else if (roll < 65)
            begin
                send_item(KIND_VOTE,
                          to_fixed(edge_index(w, 1023), $urandom_range(0, FRAC_MAX)),
                          to_fixed(edge_index(h, 511), $urandom_range(0, FRAC_MAX)), pick_time());
            end
            else if (roll < 87)
            begin
                send_item(KIND_READ,
                          to_fixed($urandom_range(base_x, base_x + 4), $urandom_range(0, FRAC_MAX)),
                          to_fixed($urandom_range(base_y, base_y + 4), $urandom_range(0, FRAC_MAX)),
                          $urandom);
            end
            else if (roll < 90)
            begin
                send_item(KIND_SPARE, $urandom, $urandom, $urandom);
            end
            else
            begin
                send_item($urandom_range(0, 1) ? KIND_READ : KIND_VOTE, $urandom, $urandom,
                          $urandom);
            end
        end
    endtask

    // Receiver: random stalls, and one long hold-off when asked for.
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            out_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            out_ready <= 1'b0;
            ready_hold = LONG_HOLD - 1;
        end
        else
        begin
            ready_hold = pick_gap();
            if (ready_hold > 0)
            begin
                out_ready <= 1'b0;
                ready_hold = ready_hold - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Every accepted result beat must match the oldest owed one, field by field.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result beat arrived with no result owed");
                fail_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("vote_accepted", 64'(want.vote_accepted), 64'(vote_accepted));
                check_field("went_to_old", 64'(want.went_to_old), 64'(went_to_old));
                check_field("old_sum", 64'(want.old_sum), 64'(old_sum));
                check_field("new_sum", 64'(want.new_sum), 64'(new_sum));
                check_field("combined_sum", 64'(want.combined_sum), 64'(combined_sum));
                check_field("saturated", 64'(want.saturated), 64'(saturated));
            end
        end
    end

    // Watchdog on the whole run, including both clearing sweeps.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_MAP_WIDTH;
        cfg_data   = '0;
        in_valid   = 1'b0;
        kind       = KIND_VOTE;
        point_x    = '0;
        point_y    = '0;
        event_time = '0;
        repeat (RESET_CYCLES)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;

        test_extreme_points();
        test_split_boundary();
        test_clear_maps();
        test_tiny_sizes();
        run_random_phase(220, 1024, 512, $urandom, 1'b1);
        test_output_backpressure();
        run_random_phase(200, 2047, 1023, '1, 1'b0);
        run_random_phase(160, 4, 4, '0, 1'b1);
        run_random_phase(220, $urandom_range(4, 1024), $urandom_range(4, 512), $urandom, 1'b1);
        run_random_phase(180, 5, 512, $urandom, 1'b1);

        wait_results_drained();
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/bevacc_pkg.sv
sv/bevacc_ram.sv
sv/bilinear_event_vote_accumulator.sv
sv/bevacc_checker.sv
tb/tb_bilinear_event_vote_accumulator.sv
